>>> hw/rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg - shared types and constants of the direct line rasteriser
// widths of the tile coordinates, the fixed-point slope and the item structs
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 16;

  // signed slope, dy/dx with FRAC_BITS fraction bits
  localparam int SLOPE_W    = COORD_BITS + FRAC_BITS + 1;
  // running y accumulator, slope times offset plus half a pixel
  localparam int ACC_W      = SLOPE_W + 1;
  // unsigned |dy| scaled by 2^FRAC_BITS, also the quotient width
  localparam int DIVIDEND_W = COORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] x_first;
    logic [COORD_BITS-1:0] y_first;
    logic [COORD_BITS-1:0] x_second;
    logic [COORD_BITS-1:0] y_second;
  } dlr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  final_pixel;
  } dlr_out_t;

  // request to the iterative divider
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [COORD_BITS-1:0] divisor;
  } dlr_div_req_t;

endpackage

>>> hw/rtl/dlr_div.sv
// ----------------------------------------------------------------------------
// dlr_div - iterative unsigned divider
// restoring division, one quotient bit per cycle, shared shift-subtract unit
// ----------------------------------------------------------------------------
module dlr_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dlr_pkg::dlr_div_req_t                req_i,
  output logic                                 done_o,
  output logic [dlr_pkg::DIVIDEND_W-1:0]       quot_o
);
  import dlr_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVIDEND_W-1:0] work_r;
  logic [COORD_BITS-1:0] rem_r;
  logic [COORD_BITS-1:0] dvs_r;

  logic [COORD_BITS:0]   shifted;
  logic [COORD_BITS+1:0] diff;
  logic                  ge;
  logic [COORD_BITS-1:0] rem_nxt;

  // remainder stays below the divisor, so one compare-subtract per bit
  always_comb begin
    shifted = {rem_r, work_r[DIVIDEND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~diff[COORD_BITS+1];
    rem_nxt = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W - 1);
        work_r <= req_i.dividend;
        rem_r  <= '0;
        dvs_r  <= req_i.divisor;
      end else if (busy_r) begin
        work_r <= {work_r[DIVIDEND_W-2:0], ge};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = work_r;

endmodule

>>> hw/rtl/direct_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// direct_line_rasterizer_core - slope-intercept line drawing on a square tile
// takes one segment per item and returns its pixels one item each
// ----------------------------------------------------------------------------
// first pixel: axis-aligned segment, in the cycle after the input item is taken;
//   sloped segment, once the bit-serial slope divider is done and ST_DIV has
//   registered the slope
// throughput: one pixel per cycle while out_ready is high, up to 64 pixels;
//   a new segment is taken only after the last pixel has left
// reset: synchronous active-low rst_n returns the sequencer to idle
// ----------------------------------------------------------------------------
module direct_line_rasterizer_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dlr_pkg::dlr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dlr_pkg::dlr_out_t out_data
);
  import dlr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    RUN_VERT  = 2'd0,
    RUN_HORIZ = 2'd1,
    RUN_SLOPE = 2'd2
  } run_kind_t;

  state_t                state_r;
  run_kind_t             kind_r;
  logic [COORD_BITS-1:0] x_r;          // current pixel x
  logic [COORD_BITS-1:0] y_r;          // current pixel y
  logic [COORD_BITS-1:0] stop_r;       // end coordinate of the stepped axis
  logic [COORD_BITS-1:0] origin_y_r;   // start y of a sloped run
  logic                  neg_r;        // sloped run heads downwards
  logic [SLOPE_W-1:0]    slope_r;
  logic [ACC_W-1:0]      acc_r;

  // endpoint ordering for the incoming item
  logic                  same_x;
  logic                  same_y;
  logic                  swap;
  logic [COORD_BITS-1:0] xa;
  logic [COORD_BITS-1:0] ya;
  logic [COORD_BITS-1:0] xb;
  logic [COORD_BITS-1:0] yb;
  logic [COORD_BITS-1:0] y_lo;
  logic [COORD_BITS-1:0] y_hi;
  logic [COORD_BITS-1:0] x_lo;
  logic [COORD_BITS-1:0] x_hi;
  logic [COORD_BITS-1:0] dy_mag;
  logic                  dy_neg;

  // stepping
  logic                  final_pix;
  logic [ACC_W-1:0]      acc_nxt;
  logic [COORD_BITS-1:0] y_step_nxt;
  logic [SLOPE_W-1:0]    quot_ext;

  logic                  in_acc;
  logic                  out_acc;

  dlr_div_req_t          div_req;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quot;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    same_x = (in_data.x_first == in_data.x_second);
    same_y = (in_data.y_first == in_data.y_second);
    swap   = (in_data.x_second < in_data.x_first);
    xa     = swap ? in_data.x_second : in_data.x_first;
    ya     = swap ? in_data.y_second : in_data.y_first;
    xb     = swap ? in_data.x_first  : in_data.x_second;
    yb     = swap ? in_data.y_first  : in_data.y_second;
    x_lo   = xa;
    x_hi   = xb;
    y_lo   = (in_data.y_first < in_data.y_second) ? in_data.y_first  : in_data.y_second;
    y_hi   = (in_data.y_first < in_data.y_second) ? in_data.y_second : in_data.y_first;
    dy_neg = (yb < ya);
    dy_mag = dy_neg ? (ya - yb) : (yb - ya);
  end

  // slope magnitude |dy| * 2^FRAC_BITS over dx, sign put back afterwards
  always_comb begin
    div_req.start    = in_acc && !same_x && !same_y;
    div_req.dividend = {dy_mag, {FRAC_BITS{1'b0}}};
    div_req.divisor  = xb - xa;
  end

  dlr_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    quot_ext   = {1'b0, div_quot};
    // running sum of the slope; the integer part is the offset rounded to nearest
    acc_nxt    = acc_r + {slope_r[SLOPE_W-1], slope_r};
    y_step_nxt = origin_y_r + acc_nxt[FRAC_BITS +: COORD_BITS];
    final_pix  = (kind_r == RUN_VERT) ? (y_r == stop_r) : (x_r == stop_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= RUN_VERT;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (same_x) begin
              // vertical run, single point included
              kind_r  <= RUN_VERT;
              x_r     <= in_data.x_first;
              y_r     <= y_lo;
              stop_r  <= y_hi;
              state_r <= ST_EMIT;
            end else if (same_y) begin
              kind_r  <= RUN_HORIZ;
              x_r     <= x_lo;
              y_r     <= in_data.y_first;
              stop_r  <= x_hi;
              state_r <= ST_EMIT;
            end else begin
              kind_r     <= RUN_SLOPE;
              x_r        <= xa;
              y_r        <= ya;
              origin_y_r <= ya;
              stop_r     <= xb;
              neg_r      <= dy_neg;
              state_r    <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            slope_r <= neg_r ? (SLOPE_W'(0) - quot_ext) : quot_ext;
            acc_r   <= ACC_HALF;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            if (final_pix) begin
              state_r <= ST_IDLE;
            end else begin
              unique case (kind_r)
                RUN_VERT: begin
                  y_r <= y_r + 1'b1;
                end
                RUN_HORIZ: begin
                  x_r <= x_r + 1'b1;
                end
                default: begin
                  x_r   <= x_r + 1'b1;
                  acc_r <= acc_nxt;
                  y_r   <= y_step_nxt;
                end
              endcase
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_data.pixel_x     = x_r;
    out_data.pixel_y     = y_r;
    out_data.final_pixel = final_pix;
  end

endmodule
